[hw/rtl/cfc_pkg.sv]
package cfc_pkg;

   localparam int PARAM_COUNT_MAX_DEFAULT = 255;
   localparam int NAME_COUNT              = 10;
   localparam int NAME_MAX_LEN            = 10;
   localparam int NAME_BITS               = NAME_MAX_LEN * 8;

   // line kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_CHECKED = 2'd1;
   localparam logic [1:0] KIND_SIMPLE  = 2'd2;
   localparam logic [1:0] KIND_OTHER   = 2'd3;

   // verdict codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNIDENT  = 2'd1;
   localparam logic [1:0] ST_BAD_SUM  = 2'd2;
   localparam logic [1:0] ST_BAD_DATA = 2'd3;

   localparam logic [3:0] CMD_UNKNOWN = 4'd0;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   localparam logic [3:0] HEX_BAD   = 4'd0;

   typedef logic [NAME_BITS-1:0] name_text_type;

   // names sit right-justified, first character in the highest used byte
   localparam name_text_type NAME_TEXT [NAME_COUNT] = '{
      name_text_type'({"GET_", "STAT"}), name_text_type'({"GET_", "REFER"}),
      name_text_type'({"GET_", "CONFIG"}), name_text_type'({"GET_", "DATE"}),
      name_text_type'({"SET_", "PHASE"}), name_text_type'({"SET_", "YF"}),
      name_text_type'({"SET_", "OS"}), name_text_type'({"SET_", "LOCAL"}),
      name_text_type'({"SET_", "START"}), name_text_type'({"SET_", "EVENT"})
   };
   localparam int NAME_LEN [NAME_COUNT] = '{8, 9, 10, 8, 9, 6, 6, 9, 9, 9};

   localparam logic [NAME_COUNT-1:0] ALL_NAMES = '1;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            run_sum;
      logic [7:0]            sum_at_dollar;
      logic                  dollar_seen;
      logic [1:0]            chars_after;
      logic [7:0]            hex_digits;
      logic [1:0]            hex_ok;
      logic                  in_token;
      logic [NAME_COUNT-1:0] match_mask;
      logic [3:0]            name_len;
      logic [NAME_COUNT-1:0] match_at_dollar;
      logic [3:0]            len_at_dollar;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      kind: KIND_NONE, run_sum: 8'd0, sum_at_dollar: 8'd0, dollar_seen: 1'b0,
      chars_after: 2'd0, hex_digits: 8'd0, hex_ok: 2'd0, in_token: 1'b0,
      match_mask: ALL_NAMES, name_len: 4'd0, match_at_dollar: ALL_NAMES,
      len_at_dollar: 4'd0
   };

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] cmd_type;
      logic       has_rid;
      logic [7:0] param_count;
      logic [7:0] comp_sum;
      logic [7:0] recv_sum;
   } verdict_type;

   function automatic int param_cap(int pmax);
      return (pmax < 255) ? pmax : 255;
   endfunction

   // add with end-around carry, then rotate left by one
   function automatic logic [7:0] sum_step(logic [7:0] s, logic [7:0] c);
      logic [8:0] wide;
      logic [7:0] folded;
      wide   = {1'b0, s} + {1'b0, c};
      folded = wide[7:0] + {7'd0, wide[8]};
      return {folded[6:0], folded[7]};
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
             (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   function automatic logic [3:0] hex_value(logic [7:0] c);
      logic [3:0] v;
      v = HEX_BAD;
      if (c >= CH_ZERO && c <= CH_NINE) v = 4'(c - CH_ZERO);
      else if (c >= CH_LOW_A && c <= CH_LOW_F) v = 4'(c - CH_LOW_A + 8'd10);
      else if (c >= CH_UP_A && c <= CH_UP_F) v = 4'(c - CH_UP_A + 8'd10);
      return v;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic name_hit(int idx, logic [3:0] pos, logic [7:0] ch);
      int         len;
      logic [7:0] expected;
      len = NAME_LEN[idx];
      if (int'(pos) >= len) return 1'b0;
      expected = NAME_TEXT[idx][(len - 1 - int'(pos))*8 +: 8];
      return expected == ch;
   endfunction

   function automatic logic [3:0] find_type(logic [NAME_COUNT-1:0] mask, logic [3:0] len);
      logic [3:0] t;
      t = CMD_UNKNOWN;
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
         if (mask[i] && int'(len) == NAME_LEN[i]) t = 4'(i + 1);
      end
      return t;
   endfunction

endpackage

[hw/rtl/cfc_scan.sv]
module cfc_scan
   import cfc_pkg::*;
#(
   parameter int PARAM_COUNT_MAX = PARAM_COUNT_MAX_DEFAULT,
   localparam int TOKEN_CAP = param_cap(PARAM_COUNT_MAX) + 3,
   localparam int TW = $clog2(TOKEN_CAP + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     frame_byte,
   input  logic           end_of_frame,
   output line_state_type upd,
   output logic [TW-1:0]  tokens_upd,
   output logic [TW-1:0]  tokens_at_dollar_upd
);

   line_state_type state_ff, state_in;
   logic [TW-1:0]  tokens_ff, tokens_in;
   logic [TW-1:0]  tad_ff, tad_in;
   logic [7:0]     folded;

   assign folded = (frame_byte >= CH_LOW_A && frame_byte <= CH_LOW_Z) ?
                   frame_byte - CASE_GAP : frame_byte;

   always_comb begin
      upd                  = state_ff;
      tokens_upd           = tokens_ff;
      tokens_at_dollar_upd = tad_ff;
      unique case (state_ff.kind)
         KIND_NONE: begin
            if (frame_byte == CH_HASH) begin
               upd.kind    = KIND_CHECKED;
               upd.run_sum = sum_step(8'd0, frame_byte);
            end else if (frame_byte == CH_BANG) begin
               upd.kind = KIND_SIMPLE;
            end else begin
               upd.kind = KIND_OTHER;
            end
         end
         KIND_CHECKED: begin
            if (frame_byte == CH_DOLLAR) begin
               upd.sum_at_dollar    = state_ff.run_sum;
               tokens_at_dollar_upd = tokens_ff;
               upd.match_at_dollar  = state_ff.match_mask;
               upd.len_at_dollar    = state_ff.name_len;
               upd.dollar_seen      = 1'b1;
               upd.chars_after      = 2'd0;
               upd.hex_digits       = 8'd0;
               upd.hex_ok           = 2'd0;
            end else if (state_ff.dollar_seen && state_ff.chars_after != 2'd2) begin
               if (is_hex(frame_byte)) begin
                  upd.hex_ok[state_ff.chars_after[0]] = 1'b1;
                  upd.hex_digits = {state_ff.hex_digits[3:0], hex_value(frame_byte)};
               end
               upd.chars_after = state_ff.chars_after + 2'd1;
            end
            upd.run_sum = sum_step(state_ff.run_sum, frame_byte);
         end
         KIND_SIMPLE: begin
         end
         KIND_OTHER: begin
         end
      endcase

      // tokeniser, shared by checked and simple lines
      if (state_ff.kind == KIND_CHECKED || state_ff.kind == KIND_SIMPLE) begin
         if (is_space(frame_byte)) begin
            upd.in_token = 1'b0;
         end else begin
            if (!state_ff.in_token) begin
               upd.in_token = 1'b1;
               if (tokens_ff < TW'(TOKEN_CAP)) tokens_upd = tokens_ff + TW'(1);
               if (tokens_upd == TW'(2)) begin
                  upd.match_mask = ALL_NAMES;
                  upd.name_len   = 4'd0;
               end
            end
            if (tokens_upd == TW'(2)) begin
               for (int i = 0; i < NAME_COUNT; i++) begin
                  if (!name_hit(i, upd.name_len, folded)) upd.match_mask[i] = 1'b0;
               end
               if (upd.name_len != 4'hF) upd.name_len = upd.name_len + 4'd1;
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      tokens_in = tokens_ff;
      tad_in    = tad_ff;
      if (step) begin
         if (end_of_frame) begin
            state_in  = LINE_CLEAR;
            tokens_in = '0;
            tad_in    = '0;
         end else begin
            state_in  = upd;
            tokens_in = tokens_upd;
            tad_in    = tokens_at_dollar_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LINE_CLEAR;
         tokens_ff <= '0;
         tad_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         tokens_ff <= tokens_in;
         tad_ff    <= tad_in;
      end
   end

endmodule

[hw/rtl/cfc_verdict.sv]
module cfc_verdict
   import cfc_pkg::*;
#(
   parameter int PARAM_COUNT_MAX = PARAM_COUNT_MAX_DEFAULT,
   localparam int PC_CAP = param_cap(PARAM_COUNT_MAX),
   localparam int TOKEN_CAP = PC_CAP + 3,
   localparam int TW = $clog2(TOKEN_CAP + 1)
) (
   input  line_state_type line,
   input  logic [TW-1:0]  tokens,
   input  logic [TW-1:0]  tokens_at_dollar,
   output verdict_type    verdict
);

   function automatic logic [7:0] cap_params(logic [TW-1:0] n);
      return (n > TW'(PC_CAP)) ? 8'(PC_CAP) : 8'(n);
   endfunction

   always_comb begin
      verdict        = '0;
      verdict.status = ST_OK;
      unique case (line.kind)
         KIND_CHECKED: begin
            if (!line.dollar_seen) begin
               verdict.status = ST_BAD_SUM;
            end else begin
               verdict.comp_sum = line.sum_at_dollar;
               if (line.hex_ok == 2'b11) verdict.recv_sum = line.hex_digits;
               if (line.hex_ok != 2'b11 || line.hex_digits != line.sum_at_dollar) begin
                  verdict.status = ST_BAD_SUM;
               end else if (tokens_at_dollar < TW'(2)) begin
                  verdict.status = ST_BAD_DATA;
               end else begin
                  verdict.cmd_type = find_type(line.match_at_dollar, line.len_at_dollar);
                  if (tokens_at_dollar >= TW'(3)) begin
                     verdict.has_rid     = 1'b1;
                     verdict.param_count = cap_params(tokens_at_dollar - TW'(3));
                  end
               end
            end
         end
         KIND_SIMPLE: begin
            if (tokens < TW'(2)) begin
               verdict.status = ST_BAD_DATA;
            end else begin
               verdict.cmd_type    = find_type(line.match_mask, line.name_len);
               verdict.param_count = cap_params(tokens - TW'(2));
            end
         end
         KIND_NONE, KIND_OTHER: begin
            verdict.status = ST_UNIDENT;
         end
      endcase
   end

endmodule

[hw/rtl/command_frame_checker.sv]
// A verdict item is offered from the result register, which takes the decode of the
// final byte held in the input register. One byte per cycle, except that a waiting
// verdict holds back only the next final byte, not ordinary bytes; the line state
// update and the verdict decode both sit combinationally between the two registers.
// Reset (synchronous, active high) clears the line state and both valid flags.
module command_frame_checker
   import cfc_pkg::*;
#(
   parameter int PARAM_COUNT_MAX = PARAM_COUNT_MAX_DEFAULT,
   localparam int PC_CAP = param_cap(PARAM_COUNT_MAX),
   localparam int TW = $clog2(PC_CAP + 4)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // end_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [1:0] status, [5:2] command_type, [6] has_request_id,
                                    // [14:7] param_count, [22:15] computed_checksum,
                                    // [30:23] received_checksum, [31] zero
);

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     byte_ff;
   logic           eof_ff;
   logic           advance;
   logic           accept;
   logic           rsp_valid_ff, rsp_valid_in;
   verdict_type    res_ff, verdict;
   line_state_type upd;
   logic [TW-1:0]  tokens_upd, tad_upd;

   assign advance    = s1_valid_ff && (!eof_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && eof_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   cfc_scan #(.PARAM_COUNT_MAX(PARAM_COUNT_MAX)) u_scan (
      .clock                (clock),
      .reset                (reset),
      .step                 (advance),
      .frame_byte           (byte_ff),
      .end_of_frame         (eof_ff),
      .upd                  (upd),
      .tokens_upd           (tokens_upd),
      .tokens_at_dollar_upd (tad_upd)
   );

   cfc_verdict #(.PARAM_COUNT_MAX(PARAM_COUNT_MAX)) u_verdict (
      .line             (upd),
      .tokens           (tokens_upd),
      .tokens_at_dollar (tad_upd),
      .verdict          (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_tdata;
         eof_ff  <= req_tlast;
      end
      if (advance && eof_ff) res_ff <= verdict;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, res_ff.recv_sum, res_ff.comp_sum, res_ff.param_count,
                        res_ff.has_rid, res_ff.cmd_type, res_ff.status};

   // a failed line reports no command details
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.status != ST_OK |->
         res_ff.cmd_type == CMD_UNKNOWN && !res_ff.has_rid && res_ff.param_count == 8'd0)
      else $error("failed verdict carries command fields");

   a_pc_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> res_ff.param_count <= 8'(PC_CAP))
      else $error("param count above cap");

   a_unident_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.status == ST_UNIDENT |->
         res_ff.comp_sum == 8'd0 && res_ff.recv_sum == 8'd0)
      else $error("unidentified line carries checksums");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> res_ff.cmd_type <= 4'(NAME_COUNT))
      else $error("command type out of range");

   a_eof_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && eof_ff |=> rsp_valid_ff)
      else $error("final byte produced no verdict");

endmodule
